>>> sv/twsh_pkg.sv
// ----------------------------------------------------------------------------
// twsh_pkg
// Shared constants, mode codes and tanh table generator for the waveshaper.
// ----------------------------------------------------------------------------
package twsh_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int TABLE_DEPTH_DEF = 256;

    // saturation_mode codes
    localparam logic [1:0] MODE_TUBE   = 2'd0;
    localparam logic [1:0] MODE_TAPE   = 2'd1;
    localparam logic [1:0] MODE_HYBRID = 2'd2;

    // drive at or below 0.01 in Q0.16 passes the sample through
    localparam logic [15:0] DRIVE_FLOOR = 16'd655;

    // x^2 bias coefficients in Q0.16 (0.2 and 0.15)
    localparam logic [13:0] TAPE_COEF = 14'd13107;
    localparam logic [13:0] HYB_COEF  = 14'd9830;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    // floor(a*b / 2^62)
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor(n / d), restoring shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table entry i: tanh(h*i/2) built as (1-e)/(1+e) with e = exp(-h)^i in Q.62,
    // result in Q.frac. Evaluated at elaboration only.
    function automatic logic [63:0] tanh_entry(input int idx, input logic [63:0] h,
                                               input int frac);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] e30;
        logic [63:0] den;
        logic [63:0] num;
        term = Q62_ONE;
        pos  = Q62_ONE;
        neg  = '0;
        e    = Q62_ONE;
        for (int k = 1; k < 32; k++)
        begin
            term = div_u64(mul_q62(term, h), 64'(k));
            if (k[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        r = pos - neg;
        for (int j = 0; j < idx; j++)
        begin
            e = mul_q62(e, r);
        end
        e30 = e >> 32;
        den = (64'd1 << 30) + e30;
        num = ((64'd1 << 30) - e30) << frac;
        return div_u64(num + (den >> 1), den);
    endfunction

endpackage

>>> sv/twsh_arg_gen.sv
// ----------------------------------------------------------------------------
// twsh_arg_gen
// Five-stage front end: drive scaling, x^2 bias and tanh argument selection.
// ----------------------------------------------------------------------------
module twsh_arg_gen #(
    parameter int SAMPLE_BITS = twsh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [15:0]                   drive_level,
    input  logic [1:0]                    saturation_mode,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS+1:0] arg1,
    output logic signed [SAMPLE_BITS+1:0] arg2,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);
    import twsh_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [SB-1:0]   x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic signed [SB+18:0]  prod2_reg;
    logic [2*SB-1:0]        sq2_reg;
    logic signed [SB+1:0]   a3_reg, a4_reg;
    logic [SB-1:0]          sq3_reg;
    logic [SB+13:0]         bp4_reg;
    logic signed [SB+1:0]   arg1_reg, arg2_reg;

    logic [17:0]            drive_mult;
    logic [SB-1:0]          ax;
    logic signed [SB+18:0]  prod2_next;
    logic [2*SB-1:0]        sq2_next;
    logic signed [SB+18:0]  a_sum;
    logic [2*SB-1:0]        sq_sum;
    logic [13:0]            coef;
    logic [SB+13:0]         bp_next;
    logic [SB+13:0]         b_sum;
    logic [SB-3:0]          bias;
    logic signed [SB+1:0]   ab;

    // m = 1 + 2*drive in Q.16
    assign drive_mult = 18'd65536 + {1'b0, drive_level, 1'b0};
    assign ax         = x1_reg[SB-1] ? SB'(-x1_reg) : SB'(x1_reg);
    assign prod2_next = x1_reg * $signed({1'b0, drive_mult});
    assign sq2_next   = (2 * SB)'(ax) * (2 * SB)'(ax);

    // round half up of x*m / 2^16 and x^2 / 2^F
    assign a_sum  = prod2_reg + $signed((SB + 19)'(32768));
    assign sq_sum = sq2_reg + ((2 * SB)'(1) << (F - 1));

    always_comb
    begin
        case (saturation_mode)
            MODE_TAPE: coef = TAPE_COEF;
            default:   coef = HYB_COEF;
        endcase
    end

    assign bp_next = (SB + 14)'(sq3_reg) * (SB + 14)'(coef);
    assign b_sum   = bp4_reg + (SB + 14)'(32768);
    assign bias    = b_sum[SB+13:16];
    assign ab      = a4_reg + $signed({4'b0000, bias});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= in_sample;
            x2_reg    <= x1_reg;
            prod2_reg <= prod2_next;
            sq2_reg   <= sq2_next;
            x3_reg    <= x2_reg;
            a3_reg    <= a_sum[SB+17:16];
            sq3_reg   <= sq_sum[F+SB-1:F];
            x4_reg    <= x3_reg;
            a4_reg    <= a3_reg;
            bp4_reg   <= bp_next;
            x5_reg    <= x4_reg;
            arg2_reg  <= ab;
            case (saturation_mode)
                MODE_TUBE:   arg1_reg <= a4_reg;
                MODE_TAPE:   arg1_reg <= ab;
                MODE_HYBRID: arg1_reg <= a4_reg;
                default:     arg1_reg <= a4_reg;
            endcase
        end
    end

    assign out_valid  = v5_reg;
    assign arg1       = arg1_reg;
    assign arg2       = arg2_reg;
    assign out_sample = x5_reg;

endmodule

>>> sv/twsh_tanh_lut.sv
// ----------------------------------------------------------------------------
// twsh_tanh_lut
// Four-stage tanh lookup: index split, table read, interpolation, sign/saturate.
// ----------------------------------------------------------------------------
module twsh_tanh_lut #(
    parameter int SAMPLE_BITS      = twsh_pkg::SAMPLE_BITS_DEF,
    parameter int TANH_TABLE_DEPTH = twsh_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS+1:0] arg,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] tanh_val
);
    import twsh_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam int AW = SAMPLE_BITS + 2;
    localparam int FW = SAMPLE_BITS + 1;
    localparam int IW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PW = AW + IW;
    localparam logic [63:0] TANH_H = ((64'd1 << 62) / TANH_TABLE_DEPTH) << 3;
    localparam logic [AW-1:0] SAT_LIM = AW'(1) << (F + 2);
    localparam logic signed [SB-1:0] FULL_POS = {1'b0, {F{1'b1}}};
    localparam logic signed [SB-1:0] FULL_NEG = {1'b1, {F{1'b0}}};

    logic [F-1:0] rom [0:TANH_TABLE_DEPTH];

    for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = tanh_entry(g, TANH_H, F);
        assign rom[g] = ENTRY[F-1:0];
    end

    logic                  va_reg, vb_reg, vc_reg, vd_reg;
    logic [IW-1:0]         idx_a_reg;
    logic [FW-1:0]         fr_a_reg, fr_b_reg;
    logic                  neg_a_reg, neg_b_reg, neg_c_reg;
    logic                  sat_a_reg, sat_b_reg, sat_c_reg;
    logic [F-1:0]          t0_b_reg, t1_b_reg, t0_c_reg;
    logic [F+FW-1:0]       prod_c_reg;
    logic signed [SB-1:0]  y_d_reg;

    logic                  neg;
    logic [AW-1:0]         mag;
    logic                  sat;
    logic [PW-1:0]         p;
    logic [IW:0]           idx_full;
    logic [IW-1:0]         idx;
    logic [F-1:0]          diff;
    logic [F+FW-1:0]       prod_next;
    logic [SB-1:0]         t_sum;
    logic signed [SB-1:0]  y_next;

    // stage A: magnitude, saturation and table position
    assign neg      = arg[AW-1];
    assign mag      = neg ? AW'(-arg) : AW'(arg);
    assign sat      = mag >= SAT_LIM;
    assign p        = PW'(mag) * PW'(TANH_TABLE_DEPTH);
    assign idx_full = p[PW-1:FW];
    assign idx      = sat ? IW'(TANH_TABLE_DEPTH - 1) : idx_full[IW-1:0];

    // stage C: slope times fraction
    assign diff      = t1_b_reg - t0_b_reg;
    assign prod_next = (F + FW)'(diff) * (F + FW)'(fr_b_reg);

    // stage D: add, sign, saturate
    assign t_sum = {1'b0, t0_c_reg} + {1'b0, prod_c_reg[F+FW-1:FW]};

    always_comb
    begin
        if (sat_c_reg)
            y_next = neg_c_reg ? FULL_NEG : FULL_POS;
        else if (neg_c_reg)
            y_next = -$signed(t_sum);
        else
            y_next = $signed(t_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_a_reg  <= idx;
            fr_a_reg   <= p[FW-1:0];
            neg_a_reg  <= neg;
            sat_a_reg  <= sat;
            t0_b_reg   <= rom[idx_a_reg];
            t1_b_reg   <= rom[idx_a_reg + IW'(1)];
            fr_b_reg   <= fr_a_reg;
            neg_b_reg  <= neg_a_reg;
            sat_b_reg  <= sat_a_reg;
            t0_c_reg   <= t0_b_reg;
            prod_c_reg <= prod_next;
            neg_c_reg  <= neg_b_reg;
            sat_c_reg  <= sat_b_reg;
            y_d_reg    <= y_next;
        end
    end

    assign out_valid = vd_reg;
    assign tanh_val  = y_d_reg;

endmodule

>>> sv/twsh_post.sv
// ----------------------------------------------------------------------------
// twsh_post
// Blend, makeup gain, rounding, output clamp and pass-through select.
// ----------------------------------------------------------------------------
module twsh_post #(
    parameter int SAMPLE_BITS = twsh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [15:0]                   drive_level,
    input  logic [15:0]                   makeup_gain,
    input  logic [1:0]                    saturation_mode,
    input  logic                          bypass,
    output logic                          res_valid,
    output logic [SAMPLE_BITS-1:0]        res_sample
);
    import twsh_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 1;
    localparam logic signed [SB+1:0] LIM_POS = {3'b000, {F{1'b1}}};
    localparam logic signed [SB+1:0] LIM_NEG = {3'b111, {F{1'b0}}};

    logic                  ve_reg, vf_reg;
    logic signed [SB-1:0]  y_e_reg;
    logic signed [SB-1:0]  x_e_reg, x_f_reg;
    logic                  pass_e_reg, pass_f_reg;
    logic signed [SB+16:0] prod_f_reg;

    logic signed [SB:0]    sum_e;
    logic signed [SB-1:0]  y_blend;
    logic                  pass;
    logic signed [SB+16:0] prod_next;
    logic signed [SB+16:0] r_sum;
    logic signed [SB+1:0]  rnd;
    logic signed [SB-1:0]  clamped;

    // floor((t1+t2)/2) is an arithmetic shift of the sum
    assign sum_e   = {y1[SB-1], y1} + {y2[SB-1], y2};
    assign y_blend = (saturation_mode == MODE_HYBRID) ? sum_e[SB:1] : y1;
    assign pass    = bypass || (drive_level <= DRIVE_FLOOR) || (saturation_mode > MODE_HYBRID);

    assign prod_next = y_e_reg * $signed({1'b0, makeup_gain});
    assign r_sum     = prod_f_reg + $signed((SB + 17)'(16384));
    assign rnd       = r_sum[SB+16:15];

    always_comb
    begin
        if (rnd > LIM_POS)
            clamped = LIM_POS[SB-1:0];
        else if (rnd < LIM_NEG)
            clamped = LIM_NEG[SB-1:0];
        else
            clamped = rnd[SB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= in_valid;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_e_reg    <= y_blend;
            x_e_reg    <= in_sample;
            pass_e_reg <= pass;
            prod_f_reg <= prod_next;
            x_f_reg    <= x_e_reg;
            pass_f_reg <= pass_e_reg;
        end
    end

    assign res_valid  = vf_reg;
    assign res_sample = pass_f_reg ? x_f_reg : clamped;

endmodule

>>> sv/tanh_saturation_waveshaper.sv
// ----------------------------------------------------------------------------
// tanh_saturation_waveshaper
// Tanh soft-clip waveshaper with tube, tape and hybrid modes and makeup gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream  s_tvalid/s_tready/s_tdata: one signed sample per transaction.
//   Output stream m_tvalid/m_tready/m_tdata: one shaped sample per input.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: 0 drive_level,
//   1 makeup_gain, 2 saturation_mode, 3 bypass. cfg_ready is always high;
//   write only while no samples are in flight.
// Throughput: one sample per clock while not stalled; every stage advances together.
// Path: the first argument stage loads on the input edge; then 4 more
//   argument stages, 4 tanh lookup stages, 2 gain/round stages and the
//   output register.
// Reset (rst_n low, asynchronous): pipeline and output empty, drive 0,
//   makeup gain 1.0, tube mode, bypass off. The tanh table is constant.
// Stall: while m_tready is low the output register holds its sample; one
//   further sample is caught in a skid register, after which s_tready drops
//   and the whole pipeline freezes until the skid register drains.
// ----------------------------------------------------------------------------
module tanh_saturation_waveshaper #(
    parameter int SAMPLE_BITS      = twsh_pkg::SAMPLE_BITS_DEF,
    parameter int TANH_TABLE_DEPTH = twsh_pkg::TABLE_DEPTH_DEF,
    localparam int TDATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import twsh_pkg::*;

    localparam int SB         = SAMPLE_BITS;
    localparam int LUT_STAGES = 4;

    localparam logic [1:0] REG_DRIVE  = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;
    localparam logic [1:0] REG_BYPASS = 2'd3;

    logic [15:0] drive_reg;
    logic [15:0] gain_reg;
    logic [1:0]  mode_reg;
    logic        bypass_reg;

    logic                  pipe_en;
    logic                  ag_valid;
    logic signed [SB+1:0]  ag_arg1, ag_arg2;
    logic signed [SB-1:0]  ag_sample;
    logic                  lut1_valid, lut2_valid;
    logic signed [SB-1:0]  lut1_y, lut2_y;
    logic signed [SB-1:0]  x_dly_reg [0:LUT_STAGES-1];
    logic                  res_valid;
    logic [SB-1:0]         res_sample;
    logic                  res_take;
    logic                  out_free;

    logic                  out_valid_reg, out_valid_next;
    logic [SB-1:0]         out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [SB-1:0]         skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg  <= 16'd0;
            gain_reg   <= 16'd32768;
            mode_reg   <= MODE_TUBE;
            bypass_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DRIVE:  drive_reg  <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_BYPASS: bypass_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // pipeline runs whenever the skid register is empty
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    twsh_arg_gen #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_arg_gen (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (pipe_en),
        .in_valid        (s_tvalid),
        .in_sample       ($signed(s_tdata[SB-1:0])),
        .drive_level     (drive_reg),
        .saturation_mode (mode_reg),
        .out_valid       (ag_valid),
        .arg1            (ag_arg1),
        .arg2            (ag_arg2),
        .out_sample      (ag_sample)
    );

    twsh_tanh_lut #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lut1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (ag_valid),
        .arg       (ag_arg1),
        .out_valid (lut1_valid),
        .tanh_val  (lut1_y)
    );

    twsh_tanh_lut #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lut2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (ag_valid),
        .arg       (ag_arg2),
        .out_valid (lut2_valid),
        .tanh_val  (lut2_y)
    );

    // raw sample rides alongside the lookup stages for pass-through
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x_dly_reg[0] <= ag_sample;
            for (int i = 1; i < LUT_STAGES; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
            end
        end
    end

    twsh_post #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (pipe_en),
        .in_valid        (lut1_valid && lut2_valid),
        .y1              (lut1_y),
        .y2              (lut2_y),
        .in_sample       (x_dly_reg[LUT_STAGES-1]),
        .drive_level     (drive_reg),
        .makeup_gain     (gain_reg),
        .saturation_mode (mode_reg),
        .bypass          (bypass_reg),
        .res_valid       (res_valid),
        .res_sample      (res_sample)
    );

    assign res_take = pipe_en && res_valid;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_take;
                out_data_next  = res_sample;
            end
        end
        else if (res_take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(out_data_reg);

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a sample while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid register did not move into output register");

    a_lut_valid_align: assert property (@(posedge clk) disable iff (!rst_n)
        lut1_valid == lut2_valid)
        else $error("tanh lookup pipelines out of step");
`endif

endmodule
